// ===== rtl/swm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared sizes, types and pipeline payloads of the sliding window median.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 5;
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W       = (CFG_W > LEN_W) ? CFG_W : LEN_W;
  localparam int OUT_W       = SAMPLE_BITS + 1;
  localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((OUT_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]       med_t;
  typedef logic [LEN_W-1:0]              len_t;
  typedef logic [CMP_W-1:0]              cmpw_t;
  typedef logic [CFG_W-1:0]              cfg_t;
  typedef logic [MAX_WINDOW-1:0]         act_t;
  typedef logic [IN_DATA_W-1:0]          in_data_t;
  typedef logic [OUT_DATA_W-1:0]         out_data_t;

  localparam cfg_t CFG_RESET = cfg_t'(3);

  // Window snapshot: newest sample at index 0.
  typedef struct packed {
    sample_t [MAX_WINDOW-1:0] win;
    act_t                     act;
    len_t                     len;
  } swm_win_t;

  // prec[i][j] set when element j sorts ahead of element i.
  typedef struct packed {
    sample_t [MAX_WINDOW-1:0] win;
    act_t                     act;
    len_t                     len;
    act_t [MAX_WINDOW-1:0]    prec;
  } swm_cmp_t;

endpackage
`default_nettype wire

// ===== rtl/swm_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swm_window
// Delay line, sample count and window length; registers a window snapshot.
// ----------------------------------------------------------------------------
module swm_window (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire swm_pkg::cfg_t     cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire swm_pkg::sample_t  in_sample,
  input  wire logic              in_first,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output swm_pkg::swm_win_t      dn_data
);

  swm_pkg::cfg_t     cfg_r;
  swm_pkg::len_t     seen_r;
  swm_pkg::len_t     seen_base;
  swm_pkg::len_t     seen_nxt;
  swm_pkg::len_t     len_eff;
  swm_pkg::sample_t  hist_r   [swm_pkg::MAX_WINDOW];
  swm_pkg::sample_t  hist_nxt [swm_pkg::MAX_WINDOW];
  swm_pkg::swm_win_t data_r;
  swm_pkg::swm_win_t data_nxt;
  logic              v_r;
  logic              emit;
  logic              fire;

  assign in_ready = !v_r || dn_ready;
  assign fire     = in_valid && in_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    if (cfg_r == '0) begin
      len_eff = swm_pkg::len_t'(1);
    end else if (swm_pkg::cmpw_t'(cfg_r) > swm_pkg::cmpw_t'(swm_pkg::MAX_WINDOW)) begin
      len_eff = swm_pkg::len_t'(swm_pkg::MAX_WINDOW);
    end else begin
      len_eff = swm_pkg::len_t'(cfg_r);
    end

    seen_base = in_first ? '0 : seen_r;
    seen_nxt  = (seen_base == swm_pkg::len_t'(swm_pkg::MAX_WINDOW)) ?
                seen_base : seen_base + swm_pkg::len_t'(1);
    emit      = (seen_nxt >= len_eff);

    hist_nxt[0] = in_sample;
    for (int k = 1; k < swm_pkg::MAX_WINDOW; k++) begin
      hist_nxt[k] = in_first ? '0 : hist_r[k-1];
    end

    for (int k = 0; k < swm_pkg::MAX_WINDOW; k++) begin
      data_nxt.win[k] = hist_nxt[k];
      data_nxt.act[k] = (swm_pkg::len_t'(k) < len_eff);
    end
    data_nxt.len = len_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= swm_pkg::CFG_RESET;
      seen_r <= '0;
      v_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      if (in_ready) begin
        v_r <= in_valid && emit;
      end
      if (fire) begin
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hist_r <= hist_nxt;
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swm_rank.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swm_rank
// Pairwise compare of the window; registers the sort order matrix.
// ----------------------------------------------------------------------------
module swm_rank (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire swm_pkg::swm_win_t up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output swm_pkg::swm_cmp_t      dn_data
);

  swm_pkg::swm_cmp_t data_r;
  swm_pkg::swm_cmp_t data_nxt;
  logic              v_r;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.win = up_data.win;
    data_nxt.act = up_data.act;
    data_nxt.len = up_data.len;
    for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
      for (int j = 0; j < swm_pkg::MAX_WINDOW; j++) begin
        data_nxt.prec[i][j] = up_data.act[j] && (i != j) &&
          (($signed(up_data.win[j]) < $signed(up_data.win[i])) ||
           ((up_data.win[j] == up_data.win[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swm_select.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swm_select
// Rank count, pick of the two middle samples and their sum; result register.
// ----------------------------------------------------------------------------
module swm_select (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire swm_pkg::swm_cmp_t up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output swm_pkg::med_t          dn_median
);

  swm_pkg::len_t    rank [swm_pkg::MAX_WINDOW];
  swm_pkg::len_t    idx_lo;
  swm_pkg::len_t    idx_hi;
  swm_pkg::sample_t lo;
  swm_pkg::sample_t hi;
  swm_pkg::med_t    med_nxt;
  swm_pkg::med_t    med_r;
  logic             v_r;

  assign up_ready  = !v_r || dn_ready;
  assign dn_valid  = v_r;
  assign dn_median = med_r;

  always_comb begin
    idx_lo = (up_data.len - swm_pkg::len_t'(1)) >> 1;
    idx_hi = up_data.len >> 1;
    lo     = '0;
    hi     = '0;
    for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
      rank[i] = swm_pkg::len_t'($countones(up_data.prec[i]));
      if (up_data.act[i] && (rank[i] == idx_lo)) begin
        lo = lo | up_data.win[i];
      end
      if (up_data.act[i] && (rank[i] == idx_hi)) begin
        hi = hi | up_data.win[i];
      end
    end
    med_nxt = swm_pkg::med_t'(lo) + swm_pkg::med_t'(hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      med_r <= med_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median
// Median of the newest window_length samples, output as twice the median.
// ----------------------------------------------------------------------------
//  channel | direction | payload                        | handshake
//  in      | slave     | tdata: sample, tuser: first    | in_tvalid / in_tready
//  out     | master    | tdata: median_twice            | out_tvalid / out_tready
//  cfg     | slave     | data: window_length            | cfg_valid / cfg_ready
//
//  One item per cycle while out is not stalled; a result passes the window,
//  compare and select registers in turn and stays on out until taken.
//  The three stages (window snapshot, compare matrix, rank select) each hold
//  one item and move on when the stage ahead is empty or moving.
//  Items that arrive before the window fills update the delay line only.
//  Reset is synchronous; no clearing pass, the block is ready right after it.
// ----------------------------------------------------------------------------
module sliding_window_median (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire swm_pkg::in_data_t   in_tdata,   // [15:0] sample
  input  wire logic [0:0]          in_tuser,   // [0] first
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output swm_pkg::out_data_t       out_tdata,  // [16:0] median_twice
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire swm_pkg::cfg_t       cfg_data
);

  swm_pkg::swm_win_t win_data;
  swm_pkg::swm_cmp_t cmp_data;
  swm_pkg::med_t     median;
  logic              win_valid;
  logic              win_ready;
  logic              cmp_valid;
  logic              cmp_ready;

  assign cfg_ready = 1'b1;
  assign out_tdata = swm_pkg::out_data_t'($unsigned(median));

  swm_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (swm_pkg::sample_t'(in_tdata[swm_pkg::SAMPLE_BITS-1:0])),
    .in_first  (in_tuser[0]),
    .dn_valid  (win_valid),
    .dn_ready  (win_ready),
    .dn_data   (win_data)
  );

  swm_rank u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (win_valid),
    .up_ready (win_ready),
    .up_data  (win_data),
    .dn_valid (cmp_valid),
    .dn_ready (cmp_ready),
    .dn_data  (cmp_data)
  );

  swm_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (cmp_valid),
    .up_ready  (cmp_ready),
    .up_data   (cmp_data),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .dn_median (median)
  );

endmodule
`default_nettype wire

// ===== rtl/swm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the sliding window median, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire swm_pkg::out_data_t out_tdata,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid right after reset");

  a_in_flows: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >> swm_pkg::OUT_W) == '0))
    else $error("out pad bits not zero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("cfg write refused");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
`default_nettype wire
